[design/smna_pkg.sv]
package smna_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AccW  = 72;

  // group order n and fold constant 2^256 - n
  localparam logic [255:0] OrderN =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
  localparam logic [255:0] FoldC =
    256'h00000000000000000000000000000001_4551231950B75FC4_402DA1732FC9BEBF;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_NEG = 2'd2,
    OP_MUL = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_NEGX,
    CMD_NEGY,
    CMD_ADD,
    CMD_ADDC,
    CMD_SUBN,
    CMD_FOLD,
    CMD_MUL,
    CMD_STORE
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEGY,
    S_NEGX,
    S_ADD,
    S_ADDC,
    S_MUL,
    S_STORE,
    S_CHECK,
    S_FOLD,
    S_RED1,
    S_RED2,
    S_OUT
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] i;
    logic [2:0] j;
    logic [3:0] k;
  } ctrl_t;

  typedef struct packed {
    logic hi_zero;
  } status_t;

endpackage

[design/smna_if.sv]
interface smna_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;

  modport source (output valid, req_type, a_limb0, a_limb1, a_limb2, a_limb3,
                  b_limb0, b_limb1, b_limb2, b_limb3, input ready);
  modport sink (input valid, req_type, a_limb0, a_limb1, a_limb2, a_limb3,
                b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface smna_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_limb0;
  logic [63:0] res_limb1;
  logic [63:0] res_limb2;
  logic [63:0] res_limb3;
  logic        res_is_zero;

  modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3,
                  res_is_zero, input ready);
  modport sink (input valid, res_limb0, res_limb1, res_limb2, res_limb3,
                res_is_zero, output ready);
endinterface

[design/smna_datapath.sv]
module smna_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smna_pkg::ctrl_t    ctrl_i,
  input  logic [255:0]       a_i,
  input  logic [255:0]       b_i,
  output smna_pkg::status_t  status_o,
  output logic [255:0]       res_o
);

  logic [255:0] x_q;
  logic [255:0] y_q;
  logic [511:0] t_q;
  logic [smna_pkg::AccW-1:0] acc_q;
  logic [63:0]  prod_q;
  logic         prod_v_q;
  logic         carry_q;

  logic [31:0]  x_word;
  logic [31:0]  y_word;
  logic [63:0]  prod_add;
  logic [smna_pkg::AccW-1:0] acc_mul;
  logic [smna_pkg::AccW-1:0] acc_col;
  logic [256:0] add_sum;

  assign x_word   = x_q[ctrl_i.i*smna_pkg::WordW +: smna_pkg::WordW];
  assign y_word   = y_q[ctrl_i.j*smna_pkg::WordW +: smna_pkg::WordW];
  assign prod_add = prod_v_q ? prod_q : 64'd0;
  assign acc_mul  = acc_q + {8'd0, prod_add};
  // column sum with the addend word of the same column
  assign acc_col  = acc_mul + {40'd0, t_q[ctrl_i.k*smna_pkg::WordW +: smna_pkg::WordW]};
  assign add_sum  = {1'b0, x_q} + {1'b0, y_q};

  assign status_o.hi_zero = (t_q[511:256] == 256'd0);
  assign res_o            = t_q[255:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= (ctrl_i.cmd == smna_pkg::CMD_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, x_word} * {32'd0, y_word};
    case (ctrl_i.cmd)
      smna_pkg::CMD_LOAD: begin
        x_q   <= a_i;
        y_q   <= b_i;
        t_q   <= '0;
        acc_q <= '0;
      end
      smna_pkg::CMD_NEGX: begin
        t_q[255:0] <= (x_q == 256'd0) ? 256'd0 : smna_pkg::OrderN - x_q;
      end
      smna_pkg::CMD_NEGY: begin
        y_q <= (y_q == 256'd0) ? 256'd0 : smna_pkg::OrderN - y_q;
      end
      smna_pkg::CMD_ADD: begin
        {carry_q, t_q[255:0]} <= add_sum;
      end
      smna_pkg::CMD_ADDC: begin
        if (carry_q) begin
          t_q[255:0] <= t_q[255:0] + smna_pkg::FoldC;
        end
      end
      smna_pkg::CMD_SUBN: begin
        if (t_q[255:0] >= smna_pkg::OrderN) begin
          t_q[255:0] <= t_q[255:0] - smna_pkg::OrderN;
        end
      end
      smna_pkg::CMD_FOLD: begin
        x_q          <= t_q[511:256];
        y_q          <= smna_pkg::FoldC;
        t_q[511:256] <= '0;
        acc_q        <= '0;
      end
      smna_pkg::CMD_MUL: begin
        acc_q <= acc_mul;
      end
      smna_pkg::CMD_STORE: begin
        t_q[ctrl_i.k*smna_pkg::WordW +: smna_pkg::WordW] <= acc_col[31:0];
        acc_q <= {32'd0, acc_col[smna_pkg::AccW-1:32]};
      end
      default: begin
      end
    endcase
  end

endmodule

[design/smna_ctrl.sv]
module smna_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_type_i,
  output logic               req_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  input  smna_pkg::status_t  status_i,
  output smna_pkg::ctrl_t    ctrl_o
);

  smna_pkg::state_e state_q, state_d;
  logic [3:0] k_q, k_d;
  logic [2:0] i_q, i_d;
  logic [2:0] nyl_q, nyl_d;

  logic [3:0] k_max;
  logic [3:0] k_nxt;
  logic [2:0] i_hi;
  logic [3:0] i_lo_nxt;

  assign k_max    = {1'b0, nyl_q} + 4'd8;
  assign k_nxt    = k_q + 4'd1;
  assign i_hi     = (k_q > 4'd7) ? 3'd7 : k_q[2:0];
  assign i_lo_nxt = (k_nxt > {1'b0, nyl_q}) ? k_nxt - {1'b0, nyl_q} : 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smna_pkg::S_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      nyl_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      nyl_q   <= nyl_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    i_d     = i_q;
    nyl_d   = nyl_q;
    unique case (state_q)
      smna_pkg::S_IDLE: begin
        if (req_valid_i) begin
          k_d   = '0;
          i_d   = '0;
          nyl_d = 3'd7;
          unique case (smna_pkg::op_e'(req_type_i))
            smna_pkg::OP_ADD: state_d = smna_pkg::S_ADD;
            smna_pkg::OP_SUB: state_d = smna_pkg::S_NEGY;
            smna_pkg::OP_NEG: state_d = smna_pkg::S_NEGX;
            default:          state_d = smna_pkg::S_MUL;
          endcase
        end
      end
      smna_pkg::S_NEGY: state_d = smna_pkg::S_ADD;
      smna_pkg::S_NEGX: state_d = smna_pkg::S_OUT;
      smna_pkg::S_ADD:  state_d = smna_pkg::S_ADDC;
      smna_pkg::S_ADDC: state_d = smna_pkg::S_RED2;
      smna_pkg::S_MUL: begin
        if (i_q == i_hi) begin
          state_d = smna_pkg::S_STORE;
        end else begin
          i_d = i_q + 3'd1;
        end
      end
      smna_pkg::S_STORE: begin
        if (k_q == k_max) begin
          state_d = smna_pkg::S_CHECK;
        end else begin
          k_d     = k_nxt;
          i_d     = i_lo_nxt[2:0];
          // the top column only drains the carry
          state_d = (k_nxt == k_max) ? smna_pkg::S_STORE : smna_pkg::S_MUL;
        end
      end
      smna_pkg::S_CHECK: begin
        state_d = status_i.hi_zero ? smna_pkg::S_RED1 : smna_pkg::S_FOLD;
      end
      smna_pkg::S_FOLD: begin
        k_d     = '0;
        i_d     = '0;
        nyl_d   = 3'd4;
        state_d = smna_pkg::S_MUL;
      end
      smna_pkg::S_RED1: state_d = smna_pkg::S_RED2;
      smna_pkg::S_RED2: state_d = smna_pkg::S_OUT;
      smna_pkg::S_OUT: begin
        if (res_ready_i) begin
          state_d = smna_pkg::S_IDLE;
        end
      end
      default: state_d = smna_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o.cmd  = smna_pkg::CMD_NOP;
    ctrl_o.i    = i_q;
    ctrl_o.j    = 3'(k_q - {1'b0, i_q});
    ctrl_o.k    = k_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      smna_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.cmd = smna_pkg::CMD_LOAD;
        end
      end
      smna_pkg::S_NEGY:  ctrl_o.cmd = smna_pkg::CMD_NEGY;
      smna_pkg::S_NEGX:  ctrl_o.cmd = smna_pkg::CMD_NEGX;
      smna_pkg::S_ADD:   ctrl_o.cmd = smna_pkg::CMD_ADD;
      smna_pkg::S_ADDC:  ctrl_o.cmd = smna_pkg::CMD_ADDC;
      smna_pkg::S_MUL:   ctrl_o.cmd = smna_pkg::CMD_MUL;
      smna_pkg::S_STORE: ctrl_o.cmd = smna_pkg::CMD_STORE;
      smna_pkg::S_CHECK: ctrl_o.cmd = smna_pkg::CMD_NOP;
      smna_pkg::S_FOLD:  ctrl_o.cmd = smna_pkg::CMD_FOLD;
      smna_pkg::S_RED1:  ctrl_o.cmd = smna_pkg::CMD_SUBN;
      smna_pkg::S_RED2:  ctrl_o.cmd = smna_pkg::CMD_SUBN;
      smna_pkg::S_OUT:   res_valid_o = 1'b1;
      default:           ctrl_o.cmd = smna_pkg::CMD_NOP;
    endcase
  end

endmodule

[design/scalar_mod_n_alu.sv]
// channel | dir | payload
// req_i   | in  | req_type, a_limb0..a_limb3, b_limb0..b_limb3
// res_o   | out | res_limb0..res_limb3, res_is_zero
//
// one item at a time; ready only while idle, result held until taken
// add sums, folds the carry and subtracts n if needed; subtract negates b first
// negate forms n - a; multiply: 8x8 word product on the single 32x32 multiplier,
// then folds the high half by 2^256 - n while nonzero and subtracts n conditionally
// asynchronous active-low reset returns the controller to idle
// a stalled result keeps the block busy and holds off the next item
module scalar_mod_n_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  smna_req_if.sink    req_i,
  smna_res_if.source  res_o
);

  smna_pkg::ctrl_t   ctrl;
  smna_pkg::status_t status;
  logic [255:0]      a_word;
  logic [255:0]      b_word;
  logic [255:0]      res_word;

  // operands as flat 256-bit words, limb 0 least significant
  assign a_word = {req_i.a_limb3, req_i.a_limb2, req_i.a_limb1, req_i.a_limb0};
  assign b_word = {req_i.b_limb3, req_i.b_limb2, req_i.b_limb1, req_i.b_limb0};

  // sequencer: picks the operation flow and walks product columns
  smna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // operand, product and accumulator registers with the shared multiplier
  smna_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .a_i      (a_word),
    .b_i      (b_word),
    .status_o (status),
    .res_o    (res_word)
  );

  // result stays in the low product register while the item waits
  assign res_o.res_limb0   = res_word[63:0];
  assign res_o.res_limb1   = res_word[127:64];
  assign res_o.res_limb2   = res_word[191:128];
  assign res_o.res_limb3   = res_word[255:192];
  assign res_o.res_is_zero = (res_word == 256'd0);

endmodule
